### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

### rtl/trcc_pkg.sv
// ----------------------------------------------------------------------------
// trcc_pkg
// types, codes and constants of the timed relay channel controller
// ----------------------------------------------------------------------------
package trcc_pkg;
  localparam int DefChannelCount = 16;
  localparam int MaxChannels     = 16;

  localparam logic [3:0] K_SCAN = 4'd0, K_SEC = 4'd1, K_INP = 4'd2, K_ON = 4'd3,
                         K_OFF = 4'd4, K_ASK = 4'd5, K_ADI = 4'd6, K_ADO = 4'd7,
                         K_SRT = 4'd8, K_UNK = 4'd9, K_BAD = 4'd10;

  localparam logic [2:0] R_ONOFF = 3'd0, R_ALIVE = 3'd1, R_INPUT = 3'd2, R_OUTPUT = 3'd3,
                         R_TIME = 3'd4, R_ERROR = 3'd5, R_RELAY = 3'd6;

  localparam logic [2:0] CFG_RELOAD = 3'd0, CFG_SPS = 3'd1, CFG_TMIN = 3'd2,
                         CFG_TMAX = 3'd3, CFG_ENABLE = 3'd4;

  localparam logic [15:0] CODE_OK = 16'd0, CODE_ALREADY = 16'd1, CODE_INVALID = 16'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [6:0]  channel;
    logic [15:0] time_param;
    logic [15:0] input_mask;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  reply_kind;
    logic [6:0]  reply_channel;
    logic [15:0] reply_value;
    logic [15:0] relay_mask;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_word_t;
endpackage

### rtl/trcc_if.sv
// ----------------------------------------------------------------------------
// trcc_if
// valid/ready channel carrying one word of a given type
// ----------------------------------------------------------------------------
interface trcc_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/timed_relay_channel_controller.sv
// ----------------------------------------------------------------------------
// timed_relay_channel_controller
// timed relay channels with a keep-alive watchdog
// ----------------------------------------------------------------------------
// usage: in_ takes scan ticks, second ticks, input samples and decoded
// commands; out_ gives at most one reply word per input word. The user must
// write the five cfg_ registers (index 0..4) only while the block is idle;
// the block does not enforce it. one word at a time: in_ready drops while a
// word is processed and while a reply word waits in the output register.
// a scan tick visits one channel per cycle (channels 16 and above are not
// visited) through a shared compare and multiply unit. an srt query runs a
// restoring divider, one quotient bit per cycle.
// while the receiver stalls the block waits with the reply and takes no
// new word.
// reset: all channels idle, relays off, registers at their defaults,
// watchdog loaded with the reload value.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module timed_relay_channel_controller import trcc_pkg::*; #(
  parameter int CHANNEL_COUNT = DefChannelCount
) (
  input logic clk,
  input logic rst_n,
  trcc_if.sink   in_ch,
  trcc_if.source out_ch,
  trcc_if.sink   cfg_ch
);
  localparam int NC = (CHANNEL_COUNT < MaxChannels) ? CHANNEL_COUNT : MaxChannels;
  localparam int CW = (NC > 1) ? $clog2(NC) : 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DIV = 3'd2, S_OUT = 3'd3;

  logic [2:0]  state_r;
  in_word_t    cmd_r;
  logic [15:0] reload_r, tmin_r, tmax_r, enable_r;
  logic [9:0]  sps_r;
  logic [NC-1:0] inp_r, relay_r, armed_r;
  logic [15:0] preset_r [NC];
  logic [31:0] scans_r [NC];
  logic [15:0] alive_r;
  logic [CW-1:0] idx_r;
  logic [5:0]  step_r;
  logic [31:0] quo_r;
  logic [9:0]  rem_r;
  out_word_t   out_r;
  logic        ovalid_r;

  logic [9:0]  sps;
  logic        ok;
  logic [CW-1:0] ch;
  logic [25:0] limit;
  logic [10:0] trial;

  assign sps = (sps_r == 10'd0) ? 10'd1 : sps_r;
  assign ch  = cmd_r.channel[CW-1:0];
  assign ok  = ({25'd0, cmd_r.channel} < 32'(NC)) && enable_r[cmd_r.channel[3:0]];
  assign limit = preset_r[idx_r] * sps;
  assign trial = {rem_r, quo_r[31]} - {1'b0, sps};

  assign in_ch.ready  = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= 16'd60; sps_r <= 10'd10; tmin_r <= 16'd1; tmax_r <= 16'hffff;
      enable_r <= 16'd6;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        CFG_RELOAD: reload_r <= cfg_ch.data.data;
        CFG_SPS:    sps_r    <= cfg_ch.data.data[9:0];
        CFG_TMIN:   tmin_r   <= cfg_ch.data.data;
        CFG_TMAX:   tmax_r   <= cfg_ch.data.data;
        CFG_ENABLE: enable_r <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ovalid_r <= 1'b0; inp_r <= '0; relay_r <= '0; armed_r <= '0;
      alive_r <= 16'd60; idx_r <= '0; step_r <= '0;
      for (int i = 0; i < NC; i++) begin
        preset_r[i] <= '0; scans_r[i] <= '0;
      end
    end else begin
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && !ovalid_r) begin
            cmd_r <= in_ch.data;
            idx_r <= '0;
            state_r <= (in_ch.data.kind == K_SCAN) ? S_SCAN : S_OUT;
          end
        end
        S_SCAN: begin
          // one channel per cycle
          logic rl, ar; logic [15:0] ps; logic [31:0] sc;
          rl = relay_r[idx_r]; ar = armed_r[idx_r]; ps = preset_r[idx_r]; sc = scans_r[idx_r];
          if (inp_r[idx_r]) begin
            if (ps != 0 && !rl && alive_r != 0 && ar) begin sc = '0; rl = 1'b1; end
          end else if (ps != 0 && rl) begin rl = 1'b0; ps = '0; ar = 1'b0; end
          // a channel dropped above compares against a zero limit
          if (sc == ((ps != 0) ? {6'd0, limit} : 32'd0)) begin
            rl = 1'b0; ps = '0; ar = 1'b0;
          end
          else sc = sc + {31'd0, rl};
          if (!ar || alive_r == 0) begin rl = 1'b0; ps = '0; ar = 1'b0; end
          relay_r[idx_r] <= rl; armed_r[idx_r] <= ar; preset_r[idx_r] <= ps;
          scans_r[idx_r] <= sc;
          if (32'(idx_r) == NC - 1) state_r <= S_OUT;
          else idx_r <= idx_r + 1'b1;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (!trial[10]) begin rem_r <= trial[9:0]; quo_r <= {quo_r[30:0], 1'b1}; end
          else begin rem_r <= {rem_r[8:0], quo_r[31]}; quo_r <= {quo_r[30:0], 1'b0}; end
          if (step_r == 6'd31) begin
            state_r <= S_OUT; step_r <= 6'd32;
          end else step_r <= step_r + 6'd1;
        end
        S_OUT: begin
          out_word_t o;
          logic send;
          o = '{cmd_r.kind == K_UNK ? R_ERROR : R_ONOFF, cmd_r.channel, 16'd0, 16'd0};
          send = 1'b1;
          case (cmd_r.kind)
            K_SCAN: begin
              o.reply_kind = R_RELAY; o.reply_channel = '0;
              o.relay_mask = 16'(relay_r);
            end
            K_SEC: begin send = 1'b0; if (alive_r != 0) alive_r <= alive_r - 16'd1; end
            K_INP: begin send = 1'b0; inp_r <= NC'(cmd_r.input_mask & 16'hfffe); end
            K_ON: begin
              if (!(cmd_r.time_param < tmax_r && cmd_r.time_param >= tmin_r)) send = 1'b0;
              else if (!ok) o.reply_value = CODE_INVALID;
              else if (relay_r[ch]) o.reply_value = CODE_ALREADY;
              else begin preset_r[ch] <= cmd_r.time_param; armed_r[ch] <= 1'b1; end
            end
            K_OFF: begin
              if (!ok) o.reply_value = CODE_INVALID;
              else if (armed_r[ch]) armed_r[ch] <= 1'b0;
              else o.reply_value = CODE_ALREADY;
            end
            K_ASK: begin o.reply_kind = R_ALIVE; alive_r <= reload_r; end
            K_ADI: begin
              o.reply_kind = R_INPUT;
              o.reply_value = ok ? {15'd0, inp_r[ch]} : CODE_INVALID;
            end
            K_ADO: begin
              o.reply_kind = R_OUTPUT;
              if (!ok) o.reply_value = CODE_INVALID;
              else begin
                o.reply_value = {15'd0, relay_r[ch]};
                if (preset_r[ch] != 0) alive_r <= reload_r;
              end
            end
            K_SRT: begin
              o.reply_kind = R_TIME;
              if (ok && step_r != 6'd32) begin
                send = 1'b0; quo_r <= scans_r[ch]; rem_r <= '0; step_r <= '0;
                state_r <= S_DIV;
              end else if (ok) begin
                o.reply_value = (quo_r[31:16] != 0) ? 16'hffff : quo_r[15:0];
                if (!relay_r[ch]) scans_r[ch] <= '0;
              end
            end
            K_UNK: begin o.reply_channel = '0; o.reply_value = 16'd1; end
            default: send = 1'b0;
          endcase
          if (state_r == S_OUT && !(cmd_r.kind == K_SRT && ok && step_r != 6'd32)) begin
            step_r <= '0;
            if (send) begin out_r <= o; ovalid_r <= 1'b1; end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_busy_not_ready, clk, rst_n, (state_r != S_IDLE) |-> !in_ch.ready)
  `ASSERT_NEXT(a_scan_ends, clk, rst_n, (state_r == S_SCAN && 32'(idx_r) == NC - 1),
               state_r == S_OUT)
  `ASSERT_NEXT(a_div_ends, clk, rst_n, (state_r == S_DIV && step_r == 6'd31),
               state_r == S_OUT)
endmodule
